// ===== src/qct_pkg.sv =====
// ----------------------------------------------------------------------------
// qct_pkg
// Shared widths, codes and types of the quota container table.
// ----------------------------------------------------------------------------
package qct_pkg;

    localparam int ACT_W   = 3;
    localparam int ID_W    = 6;
    localparam int QUOTA_W = 21;
    localparam int PAGE_W  = 20;
    localparam int CHILD_W = 7;
    localparam int ST_W    = 3;

    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 88;

    localparam logic [ACT_W-1:0] ACT_INIT  = 3'd0;
    localparam logic [ACT_W-1:0] ACT_QUERY = 3'd1;
    localparam logic [ACT_W-1:0] ACT_SPLIT = 3'd2;
    localparam logic [ACT_W-1:0] ACT_ALLOC = 3'd3;
    localparam logic [ACT_W-1:0] ACT_FREE  = 3'd4;

    localparam logic [ST_W-1:0] ST_OK         = 3'd0;
    localparam logic [ST_W-1:0] ST_ALLOC_FAIL = 3'd1;
    localparam logic [ST_W-1:0] ST_NO_SLOT    = 3'd2;
    localparam logic [ST_W-1:0] ST_SAT        = 3'd3;
    localparam logic [ST_W-1:0] ST_UNDERFLOW  = 3'd4;

    localparam logic [CHILD_W-1:0] CHILD_MAX = 7'd127;

    typedef struct packed {
        logic               in_use;
        logic [CHILD_W-1:0] children;
        logic [ID_W-1:0]    parent;
        logic [QUOTA_W-1:0] usage;
        logic [QUOTA_W-1:0] quota;
    } t_row;

    typedef struct packed {
        logic               can_consume;
        logic [CHILD_W-1:0] entry_children;
        logic [ID_W-1:0]    entry_parent;
        logic [QUOTA_W-1:0] entry_usage;
        logic [QUOTA_W-1:0] entry_quota;
        logic [PAGE_W-1:0]  page_out;
        logic [ID_W-1:0]    child_id;
        logic [ST_W-1:0]    status;
    } t_result;

    typedef struct packed {
        logic accept;
        logic rd_id;
        logic init_res;
        logic clr_step;
        logic clr_root;
        logic exec;
        logic probe_rd;
        logic probe_next;
        logic slot_fail;
        logic child_wr;
        logic parent_wr;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic init_go;
        logic probe_go;
        logic probe_free;
        logic probe_last;
        logic clr_last;
        logic out_free;
    } t_sts;

endpackage

// ===== src/qct_ram.sv =====
// ----------------------------------------------------------------------------
// qct_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module qct_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/qct_dp.sv =====
// ----------------------------------------------------------------------------
// qct_dp
// Datapath: container table memory, probe pointer, clearing pointer,
// action arithmetic and the output register.
// ----------------------------------------------------------------------------
module qct_dp import qct_pkg::*; #(
    parameter int NUM_CONTAINERS = 64,
    parameter int CHILD_FANOUT   = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    output t_sts               o_sts,
    input  logic [ACT_W-1:0]   i_action,
    input  logic [ID_W-1:0]    i_proc_id,
    input  logic [QUOTA_W-1:0] i_amount,
    input  logic [PAGE_W-1:0]  i_page,
    input  logic               i_cfg_we,
    input  logic [QUOTA_W-1:0] i_cfg_wdata,
    input  logic               i_out_ready,
    output logic               o_out_valid,
    output t_result            o_result
);

    localparam int IDX_W   = $clog2(NUM_CONTAINERS);
    localparam int PROBE_W = $clog2(64 * CHILD_FANOUT + 128 + NUM_CONTAINERS + 1);

    function automatic logic [QUOTA_W:0] sat_add(input logic [QUOTA_W-1:0] a,
                                                 input logic [QUOTA_W-1:0] b);
        logic [QUOTA_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s[QUOTA_W]) begin
            return {1'b1, {QUOTA_W{1'b1}}};
        end
        return s;
    endfunction

    logic [ACT_W-1:0]   r_action;
    logic [ID_W-1:0]    r_proc_id;
    logic [QUOTA_W-1:0] r_amount;
    logic [PAGE_W-1:0]  r_page;
    t_row               r_row;
    logic [ST_W-1:0]    r_status;
    logic [ID_W-1:0]    r_child;
    logic [PAGE_W-1:0]  r_page_out;
    logic               r_can;
    logic [PROBE_W-1:0] r_probe;
    logic [IDX_W-1:0]   r_clr_ptr;
    logic [QUOTA_W-1:0] r_root_quota;
    logic               r_out_valid;
    t_result            r_out;

    t_row               w_rd;
    logic [$bits(t_row)-1:0] w_rdata;
    logic               w_we;
    logic [IDX_W-1:0]   w_waddr;
    t_row               w_wdata;
    logic [IDX_W-1:0]   w_raddr;
    logic [IDX_W-1:0]   w_id_addr;
    logic               w_id_bad;
    logic [PROBE_W-1:0] w_c0;
    logic               w_start_bad;
    logic [QUOTA_W:0]   w_inc;
    logic [QUOTA_W:0]   w_par_sum;
    t_row               w_root_row;
    t_row               w_clr_row;
    t_row               w_child_row;
    t_row               w_par_row;
    t_row               w_exec_row;
    logic               w_exec_we;
    logic [ST_W-1:0]    w_exec_st;
    logic [PAGE_W-1:0]  w_exec_page;
    logic               w_exec_can;

    qct_ram #(
        .WIDTH ($bits(t_row)),
        .DEPTH (NUM_CONTAINERS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_rd        = t_row'(w_rdata);
    assign w_id_addr   = IDX_W'(r_proc_id);
    assign w_id_bad    = PROBE_W'(r_proc_id) >= PROBE_W'(NUM_CONTAINERS);
    assign w_c0        = PROBE_W'(r_proc_id) * PROBE_W'(CHILD_FANOUT) + PROBE_W'(1)
                         + PROBE_W'(w_rd.children);
    assign w_start_bad = w_c0 >= PROBE_W'(NUM_CONTAINERS);
    assign w_inc       = sat_add(w_rd.usage, QUOTA_W'(1));
    assign w_par_sum   = sat_add(r_row.usage, r_amount);

    always_comb begin
        w_root_row        = '0;
        w_root_row.quota  = r_root_quota;
        w_root_row.in_use = 1'b1;

        w_clr_row = (i_cmd.clr_root && r_clr_ptr == '0) ? w_root_row : '0;

        w_child_row        = '0;
        w_child_row.quota  = r_amount;
        w_child_row.parent = r_proc_id;
        w_child_row.in_use = 1'b1;

        w_par_row       = r_row;
        w_par_row.usage = w_par_sum[QUOTA_W-1:0];
        if (r_row.children < CHILD_MAX) begin
            w_par_row.children = r_row.children + CHILD_W'(1);
        end
    end

    always_comb begin
        w_exec_row  = w_id_bad ? '0 : w_rd;
        w_exec_we   = 1'b0;
        w_exec_st   = ST_OK;
        w_exec_page = '0;
        w_exec_can  = 1'b0;
        if (!w_id_bad) begin
            case (r_action)
                ACT_QUERY: begin
                    w_exec_can = (w_rd.usage <= w_rd.quota)
                                 && ((w_rd.quota - w_rd.usage) >= r_amount);
                end
                ACT_SPLIT: begin
                    if (w_start_bad) begin
                        w_exec_st = ST_NO_SLOT;
                    end
                end
                ACT_ALLOC: begin
                    if (r_page == '0) begin
                        w_exec_st = ST_ALLOC_FAIL;
                    end else begin
                        w_exec_row.usage  = w_inc[QUOTA_W-1:0];
                        w_exec_row.in_use = 1'b1;
                        w_exec_we         = 1'b1;
                        w_exec_page       = r_page;
                        if (w_inc[QUOTA_W]) begin
                            w_exec_st = ST_SAT;
                        end
                    end
                end
                ACT_FREE: begin
                    w_exec_page = r_page;
                    if (w_rd.usage == '0) begin
                        w_exec_st = ST_UNDERFLOW;
                    end else begin
                        w_exec_row.usage = w_rd.usage - QUOTA_W'(1);
                        w_exec_we        = 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        w_we    = 1'b0;
        w_waddr = w_id_addr;
        w_wdata = w_exec_row;
        if (i_cmd.clr_step) begin
            w_we    = 1'b1;
            w_waddr = r_clr_ptr;
            w_wdata = w_clr_row;
        end else if (i_cmd.exec) begin
            w_we    = w_exec_we;
        end else if (i_cmd.child_wr) begin
            w_we    = 1'b1;
            w_waddr = r_probe[IDX_W-1:0];
            w_wdata = w_child_row;
        end else if (i_cmd.parent_wr) begin
            w_we    = 1'b1;
            w_wdata = w_par_row;
        end
    end

    assign w_raddr = i_cmd.probe_rd ? r_probe[IDX_W-1:0] : w_id_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_ptr    <= '0;
            r_root_quota <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_root_quota <= i_cfg_wdata;
            end
            if (i_cmd.clr_step) begin
                r_clr_ptr <= o_sts.clr_last ? '0 : r_clr_ptr + IDX_W'(1);
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_action  <= i_action;
            r_proc_id <= i_proc_id;
            r_amount  <= i_amount;
            r_page    <= i_page;
        end
        if (i_cmd.rd_id) begin
            r_status   <= ST_OK;
            r_child    <= '0;
            r_page_out <= '0;
            r_can      <= 1'b0;
        end
        if (i_cmd.init_res) begin
            r_row <= (r_proc_id == '0) ? w_root_row : '0;
        end
        if (i_cmd.exec) begin
            r_row      <= w_exec_row;
            r_status   <= w_exec_st;
            r_page_out <= w_exec_page;
            r_can      <= w_exec_can;
            r_probe    <= w_c0;
        end
        if (i_cmd.probe_next) begin
            r_probe <= r_probe + PROBE_W'(1);
        end
        if (i_cmd.slot_fail) begin
            r_status <= ST_NO_SLOT;
        end
        if (i_cmd.child_wr) begin
            r_child <= ID_W'(r_probe);
        end
        if (i_cmd.parent_wr) begin
            r_row <= w_par_row;
            if (w_par_sum[QUOTA_W]) begin
                r_status <= ST_SAT;
            end
        end
        if (i_cmd.load_out) begin
            r_out.status         <= r_status;
            r_out.child_id       <= r_child;
            r_out.page_out       <= r_page_out;
            r_out.entry_quota    <= r_row.quota;
            r_out.entry_usage    <= r_row.usage;
            r_out.entry_parent   <= r_row.parent;
            r_out.entry_children <= r_row.children;
            r_out.can_consume    <= r_can;
        end
    end

    assign o_sts.init_go    = (r_action == ACT_INIT) && !w_id_bad;
    assign o_sts.probe_go   = (r_action == ACT_SPLIT) && !w_id_bad && !w_start_bad;
    assign o_sts.probe_free = !w_rd.in_use;
    assign o_sts.probe_last = r_probe == PROBE_W'(NUM_CONTAINERS - 1);
    assign o_sts.clr_last   = r_clr_ptr == IDX_W'(NUM_CONTAINERS - 1);
    assign o_sts.out_free   = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_result    = r_out;

endmodule

// ===== src/qct_ctrl.sv =====
// ----------------------------------------------------------------------------
// qct_ctrl
// Controller: sequences reads, probes, writes and clearing sweeps.
// ----------------------------------------------------------------------------
module qct_ctrl import qct_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [3:0] {
        S_RST_CLR,
        S_IDLE,
        S_READ,
        S_INIT_CLR,
        S_EXEC,
        S_PROBE_RD,
        S_PROBE_CHK,
        S_CHILD_WR,
        S_PARENT_WR,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_RST_CLR: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_cmd.accept = i_in_valid;
                if (i_in_valid) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                o_cmd.rd_id = 1'b1;
                if (i_sts.init_go) begin
                    o_cmd.init_res = 1'b1;
                    n_state        = S_INIT_CLR;
                end else begin
                    n_state = S_EXEC;
                end
            end
            S_INIT_CLR: begin
                o_cmd.clr_step = 1'b1;
                o_cmd.clr_root = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_DONE;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = i_sts.probe_go ? S_PROBE_RD : S_DONE;
            end
            S_PROBE_RD: begin
                o_cmd.probe_rd = 1'b1;
                n_state        = S_PROBE_CHK;
            end
            S_PROBE_CHK: begin
                if (i_sts.probe_free) begin
                    n_state = S_CHILD_WR;
                end else if (i_sts.probe_last) begin
                    o_cmd.slot_fail = 1'b1;
                    n_state         = S_DONE;
                end else begin
                    o_cmd.probe_next = 1'b1;
                    n_state          = S_PROBE_RD;
                end
            end
            S_CHILD_WR: begin
                o_cmd.child_wr = 1'b1;
                n_state        = S_PARENT_WR;
            end
            S_PARENT_WR: begin
                o_cmd.parent_wr = 1'b1;
                n_state         = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_RST_CLR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

// ===== src/quota_container_table_top.sv =====
// ----------------------------------------------------------------------------
// quota_container_table_top
// Table of per-process memory containers with quota and usage bookkeeping.
// ----------------------------------------------------------------------------
// Input beats arrive on the s_axis channel: tuser carries the action code and
// tdata the container index, amount and page. Each beat yields exactly one
// result beat on the m_axis channel. The root quota is set through the
// configuration write port and is used by the next init.
// One beat is worked on at a time; all table state lives in a single memory
// with one write and one registered read port. Query, alloc, free and unused
// actions read the row, execute and load the result register; split also
// probes the candidate slots one by one, reading and checking each, and if
// one is free writes the child and parent rows; init clears one row per cycle.
// A new beat can be accepted in the cycle after the result register is loaded.
// After reset the block sweeps the memory to zero and holds tready low until
// the sweep is done.
// The result sits in an output register; the next beat is accepted while
// it waits, and processing stalls only when a new result is ready and the
// previous one has still not been taken.
// ----------------------------------------------------------------------------
module quota_container_table_top import qct_pkg::*; #(
    parameter int NUM_CONTAINERS = 64,
    parameter int CHILD_FANOUT   = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // proc_id, amount, page from bit 0 up, zero padding
    input  logic [IN_DATA_W-1:0]  i_s_axis_tdata,
    // action
    input  logic [ACT_W-1:0]      i_s_axis_tuser,
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // status, child_id, page_out, entry_quota, entry_usage, entry_parent,
    // entry_children, can_consume from bit 0 up, zero padding
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata,
    input  logic                  i_cfg_we,
    input  logic [QUOTA_W-1:0]    i_cfg_wdata
);

    t_cmd    w_cmd;
    t_sts    w_sts;
    t_result w_result;

    qct_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    qct_dp #(
        .NUM_CONTAINERS (NUM_CONTAINERS),
        .CHILD_FANOUT   (CHILD_FANOUT)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .i_action     (i_s_axis_tuser),
        .i_proc_id    (i_s_axis_tdata[5:0]),
        .i_amount     (i_s_axis_tdata[26:6]),
        .i_page       (i_s_axis_tdata[46:27]),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_out_ready  (i_m_axis_tready),
        .o_out_valid  (o_m_axis_tvalid),
        .o_result     (w_result)
    );

    assign o_m_axis_tdata = OUT_DATA_W'(w_result);

endmodule

// ===== src/qct_checker.sv =====
// ----------------------------------------------------------------------------
// qct_checker
// Port-level checks of the quota container table, bound to the top level.
// ----------------------------------------------------------------------------
module qct_checker import qct_pkg::*; (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_s_axis_tvalid,
    input logic                  o_s_axis_tready,
    input logic                  o_m_axis_tvalid,
    input logic                  i_m_axis_tready,
    input logic [OUT_DATA_W-1:0] o_m_axis_tdata
);

    a_rst_no_result: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("Result beat valid straight after reset.");

    a_rst_sweep: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_s_axis_tready)
        else $error("Input beat offered ready during the clearing sweep.");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready)
        else $error("Second input beat taken while one is still being worked on.");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready)
        |=> (o_m_axis_tvalid && $stable(o_m_axis_tdata)))
        else $error("Stalled result beat changed or dropped.");

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata[2:0] <= ST_UNDERFLOW))
        else $error("Result status outside the defined codes.");

endmodule

bind quota_container_table_top qct_checker u_qct_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);

// ===== test/quota_container_table_top_tb.sv =====
// ----------------------------------------------------------------------------
// quota_container_table_top_tb
// Self-checking testbench of the quota container table.
// ----------------------------------------------------------------------------
// A directed opening covers init, query at the quota boundary, usage above
// quota, saturation, allocator failure, underflow, unused actions and splits
// whose first candidate is past the table end. Random phases then run mostly
// well-formed container trees under several root quotas. Both sides of the
// stream idle at random, and the receiver holds off once for a long stretch.
// Every result beat is checked field by field against a ledger that tracks
// the whole container table.
// ----------------------------------------------------------------------------
module quota_container_table_top_tb;
    import qct_pkg::*;

    localparam int NUM         = 64;
    localparam int FANOUT      = 8;
    localparam int LIMIT       = 600000;
    localparam int HOLD_CYCLES = 400;
    localparam int RAND_ITEMS  = 100;

    class container_ledger;
        bit [QUOTA_W-1:0] root_quota;
        bit [QUOTA_W-1:0] quota_of    [NUM];
        bit [QUOTA_W-1:0] usage_of    [NUM];
        bit [ID_W-1:0]    parent_of   [NUM];
        bit [CHILD_W-1:0] children_of [NUM];
        bit               in_use      [NUM];
        t_result          expected_results [$];
        int               errors;
        int               seen_action [8];
        int               seen_status [8];

        function void clear_table();
            foreach (in_use[k]) begin
                quota_of[k]    = '0;
                usage_of[k]    = '0;
                parent_of[k]   = '0;
                children_of[k] = '0;
                in_use[k]      = 1'b0;
            end
        endfunction

        function bit add_usage(bit [ID_W-1:0] id, bit [QUOTA_W-1:0] n);
            bit [QUOTA_W:0] sum;
            sum = {1'b0, usage_of[id]} + {1'b0, n};
            if (sum[QUOTA_W]) begin
                usage_of[id] = '1;
                return 1'b1;
            end
            usage_of[id] = sum[QUOTA_W-1:0];
            return 1'b0;
        endfunction

        function void note_accepted(bit [ACT_W-1:0] act, bit [ID_W-1:0] id,
                                    bit [QUOTA_W-1:0] amt, bit [PAGE_W-1:0] pg);
            t_result r;
            int      c;
            r = '0;
            case (act)
                ACT_INIT: begin
                    clear_table();
                    quota_of[0] = root_quota;
                    in_use[0]   = 1'b1;
                end
                ACT_QUERY: begin
                    r.can_consume = (usage_of[id] <= quota_of[id]) &&
                                    (quota_of[id] - usage_of[id] >= amt);
                end
                ACT_SPLIT: begin
                    c = int'(id) * FANOUT + 1 + int'(children_of[id]);
                    while (c < NUM && in_use[c])
                        c++;
                    if (c >= NUM) begin
                        r.status = ST_NO_SLOT;
                    end else begin
                        if (add_usage(id, amt))
                            r.status = ST_SAT;
                        if (children_of[id] < CHILD_MAX)
                            children_of[id]++;
                        quota_of[c]    = amt;
                        usage_of[c]    = '0;
                        parent_of[c]   = id;
                        children_of[c] = '0;
                        in_use[c]      = 1'b1;
                        r.child_id     = c[ID_W-1:0];
                    end
                end
                ACT_ALLOC: begin
                    if (pg == '0) begin
                        r.status = ST_ALLOC_FAIL;
                    end else begin
                        if (add_usage(id, 1))
                            r.status = ST_SAT;
                        in_use[id] = 1'b1;
                        r.page_out = pg;
                    end
                end
                ACT_FREE: begin
                    if (usage_of[id] == '0)
                        r.status = ST_UNDERFLOW;
                    else
                        usage_of[id]--;
                    r.page_out = pg;
                end
                default: begin
                end
            endcase
            r.entry_quota    = quota_of[id];
            r.entry_usage    = usage_of[id];
            r.entry_parent   = parent_of[id];
            r.entry_children = children_of[id];
            seen_action[act]++;
            seen_status[r.status]++;
            expected_results.push_back(r);
        endfunction

        function void compare_field(string name, int unsigned want, logic [31:0] got);
            if (got !== want) begin
                $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_result(logic [OUT_DATA_W-1:0] beat);
            t_result got;
            t_result want;
            got = beat[$bits(t_result)-1:0];
            if (expected_results.size() == 0) begin
                $display("%0t: result beat expected none actual %0h", $time, beat);
                errors++;
                return;
            end
            want = expected_results.pop_front();
            compare_field("status", want.status, got.status);
            compare_field("child_id", want.child_id, got.child_id);
            compare_field("page_out", want.page_out, got.page_out);
            compare_field("entry_quota", want.entry_quota, got.entry_quota);
            compare_field("entry_usage", want.entry_usage, got.entry_usage);
            compare_field("entry_parent", want.entry_parent, got.entry_parent);
            compare_field("entry_children", want.entry_children, got.entry_children);
            compare_field("can_consume", want.can_consume, got.can_consume);
        endfunction

        function int pending();
            return expected_results.size();
        endfunction
    endclass

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic [IN_DATA_W-1:0]  in_data   = '0;
    logic [ACT_W-1:0]      in_user   = '0;
    logic                  out_ready = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [QUOTA_W-1:0]    cfg_wdata = '0;
    logic                  in_ready;
    logic                  out_valid;
    logic [OUT_DATA_W-1:0] out_data;

    container_ledger ledger = new();
    bit              burst;
    bit              hold_req;
    bit              hold_active;
    int unsigned     cycles;

    quota_container_table_top #(
        .NUM_CONTAINERS (NUM),
        .CHILD_FANOUT   (FANOUT)
    ) i_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (in_valid),
        .o_s_axis_tready (in_ready),
        .i_s_axis_tdata  (in_data),
        .i_s_axis_tuser  (in_user),
        .o_m_axis_tvalid (out_valid),
        .i_m_axis_tready (out_ready),
        .o_m_axis_tdata  (out_data),
        .i_cfg_we        (cfg_we),
        .i_cfg_wdata     (cfg_wdata)
    );

    always #1 clk = ~clk;

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready)
            ledger.check_result(out_data);
    end

    initial begin : result_side
        int len;
        @(posedge clk);
        forever begin
            if (hold_req) begin
                hold_req    = 1'b0;
                hold_active = 1'b1;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_active = 1'b0;
            end else if ($urandom_range(0, 99) < 5) begin
                out_ready <= 1'b1;
                len = $urandom_range(50, 100);
                repeat (len) @(posedge clk);
            end else if ($urandom_range(0, 99) < 70) begin
                out_ready <= 1'b1;
                len = $urandom_range(1, 8);
                repeat (len) @(posedge clk);
            end else begin
                out_ready <= 1'b0;
                len = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3)
                                                 : $urandom_range(10, 40);
                repeat (len) @(posedge clk);
            end
        end
    end

    task automatic send_action(bit [ACT_W-1:0] act, bit [ID_W-1:0] id,
                               bit [QUOTA_W-1:0] amt, bit [PAGE_W-1:0] pg);
        int pick;
        int gap;
        in_valid <= 1'b1;
        in_user  <= act;
        in_data  <= {1'b0, pg, amt, id};
        do @(posedge clk); while (!in_ready);
        ledger.note_accepted(act, id, amt, pg);
        pick = $urandom_range(0, 99);
        if (burst || hold_req || hold_active || pick < 65)
            gap = 0;
        else if (pick < 90)
            gap = $urandom_range(1, 3);
        else
            gap = $urandom_range(8, 40);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (ledger.pending() != 0)
            @(posedge clk);
    endtask

    task automatic write_root_quota(bit [QUOTA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        ledger.root_quota = value;
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    function automatic bit [ID_W-1:0] pick_id();
        bit [ID_W-1:0] live [$];
        foreach (ledger.in_use[k])
            if (ledger.in_use[k])
                live.push_back(k[ID_W-1:0]);
        if (live.size() == 0 || $urandom_range(0, 9) < 3)
            return ID_W'($urandom_range(0, NUM - 1));
        return live[$urandom_range(0, live.size() - 1)];
    endfunction

    function automatic bit [QUOTA_W-1:0] pick_amount(bit [ID_W-1:0] id, bit asking);
        int unsigned room;
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2: return QUOTA_W'($urandom_range(0, 21'h1FFFFF));
            3: return QUOTA_W'($urandom_range(0, 100));
            4: return QUOTA_W'($urandom_range(0, ledger.root_quota / 4));
            default: begin
                if (!asking)
                    return QUOTA_W'($urandom_range(0, 1000));
                room = (ledger.usage_of[id] <= ledger.quota_of[id]) ?
                       ledger.quota_of[id] - ledger.usage_of[id] : 0;
                return QUOTA_W'(room + $urandom_range(0, 2) - 1);
            end
        endcase
    endfunction

    function automatic bit [PAGE_W-1:0] pick_page();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            default: return PAGE_W'($urandom_range(1, 20'hFFFFF));
        endcase
    endfunction

    task automatic random_phase(int phase);
        int            pick;
        bit [ID_W-1:0] id;
        send_action(ACT_INIT, ID_W'($urandom_range(0, NUM - 1)),
                    QUOTA_W'($urandom), PAGE_W'($urandom));
        for (int n = 0; n < RAND_ITEMS; n++) begin
            burst = (phase == 3) && (n < RAND_ITEMS / 2);
            if (phase == 2 && n == 10)
                hold_req = 1'b1;
            pick = $urandom_range(0, 99);
            id   = pick_id();
            if (pick < 3)
                send_action(ACT_INIT, id, QUOTA_W'($urandom), PAGE_W'($urandom));
            else if (pick < 28)
                send_action(ACT_QUERY, id, pick_amount(id, 1'b1), PAGE_W'($urandom));
            else if (pick < 48)
                send_action(ACT_SPLIT, id, pick_amount(id, 1'b0), PAGE_W'($urandom));
            else if (pick < 73)
                send_action(ACT_ALLOC, id, QUOTA_W'($urandom), pick_page());
            else if (pick < 93)
                send_action(ACT_FREE, id, QUOTA_W'($urandom), pick_page());
            else
                send_action(ACT_W'($urandom_range(5, 7)), id, QUOTA_W'($urandom),
                            PAGE_W'($urandom));
        end
        burst = 1'b0;
    endtask

    initial begin : stimulus
        bit [QUOTA_W-1:0] roots [4];
        ledger.clear_table();
        roots[0] = '0;
        roots[1] = 21'h100000;
        roots[2] = '1;
        roots[3] = QUOTA_W'($urandom_range(0, 21'h1FFFFF));
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        write_root_quota(21'd1000);

        send_action(ACT_QUERY, 6'd0, 21'd0, 20'd0);
        send_action(ACT_INIT, 6'd63, '1, '1);
        send_action(ACT_QUERY, 6'd0, 21'd1000, 20'd0);
        send_action(ACT_QUERY, 6'd0, 21'd1001, 20'd0);
        send_action(ACT_SPLIT, 6'd0, 21'd400, 20'd0);
        send_action(ACT_SPLIT, 6'd0, '1, 20'd0);
        send_action(ACT_QUERY, 6'd0, 21'd0, 20'd0);
        send_action(ACT_ALLOC, 6'd1, 21'd0, 20'd0);
        send_action(ACT_ALLOC, 6'd1, 21'd0, '1);
        send_action(ACT_FREE, 6'd1, 21'd0, 20'h55555);
        send_action(ACT_FREE, 6'd1, 21'd0, 20'hAAAAA);
        send_action(ACT_SPLIT, 6'd63, 21'd5, 20'd0);
        send_action(ACT_W'(5), 6'd1, 21'd7, 20'd9);
        send_action(ACT_W'(6), 6'd1, '1, '1);
        send_action(ACT_W'(7), 6'd0, 21'd0, 20'd0);
        send_action(ACT_ALLOC, 6'd0, 21'd0, 20'd1);
        send_action(ACT_QUERY, 6'd63, '1, 20'd0);
        for (int n = 0; n < 8; n++)
            send_action(ACT_SPLIT, 6'd7, 21'h100000, 20'd0);
        drain();

        for (int phase = 0; phase < 4; phase++) begin
            write_root_quota(roots[phase]);
            random_phase(phase);
            drain();
        end

        repeat (200) @(posedge clk);
        $display("Run covered %0d init, %0d query, %0d split, %0d alloc, %0d free, %0d unused.",
                 ledger.seen_action[ACT_INIT], ledger.seen_action[ACT_QUERY],
                 ledger.seen_action[ACT_SPLIT], ledger.seen_action[ACT_ALLOC],
                 ledger.seen_action[ACT_FREE],
                 ledger.seen_action[5] + ledger.seen_action[6] + ledger.seen_action[7]);
        $display("Outcomes: %0d ok, %0d allocator failed, %0d no slot, %0d saturated, %0d underflow.",
                 ledger.seen_status[ST_OK], ledger.seen_status[ST_ALLOC_FAIL],
                 ledger.seen_status[ST_NO_SLOT], ledger.seen_status[ST_SAT],
                 ledger.seen_status[ST_UNDERFLOW]);
        if (ledger.errors == 0 && ledger.pending() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
